@@ rtl/fsn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsn_pkg : shared constants, types and single-precision helpers
// Seed constants, NaN codes, the item tag carried down the pipeline, and the
// leading-zero count and round-and-pack functions used by the arithmetic units.
// ----------------------------------------------------------------------------
package fsn_pkg;

  localparam int          NEWTON_STEPS = 2;
  localparam logic [31:0] SEED_SUB     = 32'h0080_0000;
  localparam logic [31:0] SEED_ADD     = 32'h2000_0000;
  localparam logic [31:0] QNAN_POS     = 32'h7FC0_0000;
  localparam logic [31:0] QNAN_DEF     = 32'hFFC0_0000;
  localparam logic [30:0] INF_MAG      = 31'h7F80_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  typedef struct packed {
    logic        err;
    logic [31:0] num;
    logic [31:0] x;
  } fsn_tag_t;

  function automatic logic f_is_nan(input logic [31:0] v);
    return (v[30:0] > INF_MAG);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] v);
    return (v[30:0] == INF_MAG);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] v);
    return (v[30:0] == 31'd0);
  endfunction

  function automatic logic [31:0] f_quiet(input logic [31:0] v);
    return (v | QUIET_BIT);
  endfunction

  function automatic logic [4:0] f_lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd0;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) begin
          hit = 1'b1;
        end else begin
          n = n + 5'd1;
        end
      end
    end
    return n;
  endfunction

  // sig: leading one at bit 26, guard at bit 2, sticky folded into bit 0
  function automatic logic [31:0] f_round_pack(input logic sign,
                                               input logic signed [9:0] e,
                                               input logic [26:0] sig);
    logic [26:0]       m;
    logic              stk;
    logic [9:0]        sh;
    logic [24:0]       sum;
    logic              up;
    logic signed [9:0] eo;
    logic [31:0]       r;
    m   = sig;
    stk = 1'b0;
    sh  = 10'd0;
    if (e < 10'sd1) begin
      sh = 10'(10'sd1 - e);
      if (sh > 10'd26) begin
        stk = |sig;
        m   = 27'd0;
      end else begin
        stk = |(sig & ~({27{1'b1}} << sh));
        m   = sig >> sh;
      end
    end
    up  = m[2] & (m[3] | m[1] | m[0] | stk);
    sum = {1'b0, m[26:3]} + {24'd0, up};
    eo  = e + $signed({9'd0, sum[24]});
    if (e < 10'sd1) begin
      r = {sign, 7'd0, sum[23:0]};
    end else if (eo >= 10'sd255) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      r = {sign, eo[7:0], sum[22:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/fsn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsn_div : pipelined single-precision divider, num / x
// Classify and count leading zeros, normalise, one restoring quotient bit per
// stage over 26 stages, then round to nearest even. 29 register stages.
// ----------------------------------------------------------------------------
module fsn_div import fsn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  fsn_tag_t    in_tag,
  output logic        out_valid,
  output fsn_tag_t    out_tag,
  output logic [31:0] out_q
);

  localparam int QBITS = 26;

  typedef struct packed {
    fsn_tag_t          tag;
    logic              spc;
    logic [31:0]       spcv;
    logic              sign;
    logic signed [9:0] e;
    logic [23:0]       d;
  } div_side_t;

  // classify
  logic [31:0] a, b;
  logic        sign_nxt, spc_nxt;
  logic [31:0] spcv_nxt;
  logic [23:0] ma_nxt, mb_nxt;
  logic [7:0]  ea_nxt, eb_nxt;

  always_comb begin
    a        = in_tag.num;
    b        = in_tag.x;
    sign_nxt = a[31] ^ b[31];
    spc_nxt  = 1'b1;
    spcv_nxt = 32'd0;
    if (f_is_zero(b)) begin
      spcv_nxt = (f_is_zero(a) || f_is_nan(a)) ? QNAN_POS : {sign_nxt, INF_MAG};
    end else if (f_is_nan(a)) begin
      spcv_nxt = f_quiet(a);
    end else if (f_is_nan(b)) begin
      spcv_nxt = f_quiet(b);
    end else if (f_is_inf(a) && f_is_inf(b)) begin
      spcv_nxt = QNAN_DEF;
    end else if (f_is_inf(a)) begin
      spcv_nxt = {sign_nxt, INF_MAG};
    end else if (f_is_inf(b) || f_is_zero(a)) begin
      spcv_nxt = {sign_nxt, 31'd0};
    end else begin
      spc_nxt = 1'b0;
    end
    ma_nxt = {|a[30:23], a[22:0]};
    mb_nxt = {|b[30:23], b[22:0]};
    ea_nxt = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb_nxt = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  end

  logic        d0_valid_r;
  fsn_tag_t    d0_tag_r;
  logic        d0_spc_r, d0_sign_r;
  logic [31:0] d0_spcv_r;
  logic [23:0] d0_ma_r, d0_mb_r;
  logic [7:0]  d0_ea_r, d0_eb_r;
  logic [4:0]  d0_lza_r, d0_lzb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_valid_r <= 1'b0;
    end else if (en) begin
      d0_valid_r <= in_valid;
    end
    if (en) begin
      d0_tag_r  <= in_tag;
      d0_spc_r  <= spc_nxt;
      d0_spcv_r <= spcv_nxt;
      d0_sign_r <= sign_nxt;
      d0_ma_r   <= ma_nxt;
      d0_mb_r   <= mb_nxt;
      d0_ea_r   <= ea_nxt;
      d0_eb_r   <= eb_nxt;
      d0_lza_r  <= f_lzc27({ma_nxt, 3'b000});
      d0_lzb_r  <= f_lzc27({mb_nxt, 3'b000});
    end
  end

  // normalise
  logic [23:0]       na, nb;
  logic signed [9:0] e_nxt;
  logic              lt;
  div_side_t         side_nxt;

  always_comb begin
    na    = d0_ma_r << d0_lza_r;
    nb    = d0_mb_r << d0_lzb_r;
    lt    = na < nb;
    e_nxt = $signed({2'b00, d0_ea_r}) - $signed({5'd0, d0_lza_r})
          - $signed({2'b00, d0_eb_r}) + $signed({5'd0, d0_lzb_r}) + 10'sd127;
    if (lt) begin
      e_nxt = e_nxt - 10'sd1;
    end
    side_nxt.tag  = d0_tag_r;
    side_nxt.spc  = d0_spc_r;
    side_nxt.spcv = d0_spcv_r;
    side_nxt.sign = d0_sign_r;
    side_nxt.e    = e_nxt;
    side_nxt.d    = nb;
  end

  logic             iv_r [QBITS+1];
  logic [24:0]      ir_r [QBITS+1];
  logic [QBITS-1:0] iq_r [QBITS+1];
  div_side_t        is_r [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r[0] <= 1'b0;
    end else if (en) begin
      iv_r[0] <= d0_valid_r;
    end
    if (en) begin
      ir_r[0] <= lt ? {na, 1'b0} : {1'b0, na};
      iq_r[0] <= '0;
      is_r[0] <= side_nxt;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_iter
    logic        qbit;
    logic [24:0] rem_nxt;

    always_comb begin
      qbit    = ir_r[k] >= {1'b0, is_r[k].d};
      rem_nxt = qbit ? (ir_r[k] - {1'b0, is_r[k].d}) : ir_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        iv_r[k+1] <= 1'b0;
      end else if (en) begin
        iv_r[k+1] <= iv_r[k];
      end
      if (en) begin
        ir_r[k+1] <= {rem_nxt[23:0], 1'b0};
        iq_r[k+1] <= {iq_r[k][QBITS-2:0], qbit};
        is_r[k+1] <= is_r[k];
      end
    end
  end

  // round
  logic        out_valid_r;
  fsn_tag_t    out_tag_r;
  logic [31:0] out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= iv_r[QBITS];
    end
    if (en) begin
      out_tag_r <= is_r[QBITS].tag;
      out_q_r   <= is_r[QBITS].spc ? is_r[QBITS].spcv :
                   f_round_pack(is_r[QBITS].sign, is_r[QBITS].e,
                                {iq_r[QBITS], |ir_r[QBITS]});
    end
  end

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;
  assign out_q     = out_q_r;

endmodule

@@ rtl/fsn_add.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsn_add : pipelined single-precision adder, x + q
// Swap and align, add or subtract with leading-zero count, normalise, round
// to nearest even. Four register stages.
// ----------------------------------------------------------------------------
module fsn_add import fsn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  fsn_tag_t    in_tag,
  input  logic [31:0] in_q,
  output logic        out_valid,
  output fsn_tag_t    out_tag,
  output logic [31:0] out_s
);

  // swap and align
  logic [31:0] a, b, big, sml;
  logic        spc_nxt;
  logic [31:0] spcv_nxt;
  logic [7:0]  eg, es, dexp;
  logic [26:0] s27, al_nxt;

  always_comb begin
    a       = in_tag.x;
    b       = in_q;
    spc_nxt = 1'b1;
    if (f_is_nan(a)) begin
      spcv_nxt = f_quiet(a);
    end else if (f_is_nan(b)) begin
      spcv_nxt = f_quiet(b);
    end else if (f_is_inf(a) && f_is_inf(b) && (a[31] != b[31])) begin
      spcv_nxt = QNAN_DEF;
    end else if (f_is_inf(a)) begin
      spcv_nxt = a;
    end else if (f_is_inf(b)) begin
      spcv_nxt = b;
    end else if (f_is_zero(a) && f_is_zero(b)) begin
      spcv_nxt = {a[31] & b[31], 31'd0};
    end else if (f_is_zero(a)) begin
      spcv_nxt = b;
    end else if (f_is_zero(b)) begin
      spcv_nxt = a;
    end else begin
      spc_nxt  = 1'b0;
      spcv_nxt = 32'd0;
    end
    big  = (b[30:0] > a[30:0]) ? b : a;
    sml  = (b[30:0] > a[30:0]) ? a : b;
    eg   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    dexp = eg - es;
    s27  = {|sml[30:23], sml[22:0], 3'b000};
    if (dexp > 8'd26) begin
      al_nxt = {26'd0, |s27};
    end else begin
      al_nxt = (s27 >> dexp) | {26'd0, |(s27 & ~({27{1'b1}} << dexp))};
    end
  end

  logic        a0_valid_r, a0_spc_r, a0_sign_r, a0_sub_r;
  fsn_tag_t    a0_tag_r;
  logic [31:0] a0_spcv_r;
  logic [7:0]  a0_e_r;
  logic [26:0] a0_big_r, a0_al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_valid_r <= 1'b0;
    end else if (en) begin
      a0_valid_r <= in_valid;
    end
    if (en) begin
      a0_tag_r  <= in_tag;
      a0_spc_r  <= spc_nxt;
      a0_spcv_r <= spcv_nxt;
      a0_sign_r <= big[31];
      a0_sub_r  <= a[31] ^ b[31];
      a0_e_r    <= eg;
      a0_big_r  <= {|big[30:23], big[22:0], 3'b000};
      a0_al_r   <= al_nxt;
    end
  end

  // add and count
  logic [27:0]       sum;
  logic [26:0]       sig_nxt;
  logic signed [9:0] e1_nxt;

  always_comb begin
    sum = a0_sub_r ? ({1'b0, a0_big_r} - {1'b0, a0_al_r})
                   : ({1'b0, a0_big_r} + {1'b0, a0_al_r});
    if (sum[27]) begin
      sig_nxt = {sum[27:2], sum[1] | sum[0]};
      e1_nxt  = $signed({2'b00, a0_e_r}) + 10'sd1;
    end else begin
      sig_nxt = sum[26:0];
      e1_nxt  = $signed({2'b00, a0_e_r});
    end
  end

  logic        a1_valid_r, a1_spc_r, a1_sign_r, a1_zero_r;
  fsn_tag_t    a1_tag_r;
  logic [31:0] a1_spcv_r;
  logic signed [9:0] a1_e_r;
  logic [26:0] a1_sig_r;
  logic [4:0]  a1_lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_valid_r <= 1'b0;
    end else if (en) begin
      a1_valid_r <= a0_valid_r;
    end
    if (en) begin
      a1_tag_r  <= a0_tag_r;
      a1_spc_r  <= a0_spc_r;
      a1_spcv_r <= a0_spcv_r;
      a1_sign_r <= a0_sign_r;
      a1_zero_r <= (sig_nxt == 27'd0);
      a1_e_r    <= e1_nxt;
      a1_sig_r  <= sig_nxt;
      a1_lz_r   <= f_lzc27(sig_nxt);
    end
  end

  // normalise
  logic        a2_valid_r, a2_spc_r, a2_sign_r, a2_zero_r;
  fsn_tag_t    a2_tag_r;
  logic [31:0] a2_spcv_r;
  logic signed [9:0] a2_e_r;
  logic [26:0] a2_sig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_valid_r <= 1'b0;
    end else if (en) begin
      a2_valid_r <= a1_valid_r;
    end
    if (en) begin
      a2_tag_r  <= a1_tag_r;
      a2_spc_r  <= a1_spc_r;
      a2_spcv_r <= a1_spcv_r;
      a2_sign_r <= a1_sign_r;
      a2_zero_r <= a1_zero_r;
      a2_e_r    <= a1_e_r - $signed({5'd0, a1_lz_r});
      a2_sig_r  <= a1_sig_r << a1_lz_r;
    end
  end

  // round
  logic        out_valid_r;
  fsn_tag_t    out_tag_r;
  logic [31:0] out_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= a2_valid_r;
    end
    if (en) begin
      out_tag_r <= a2_tag_r;
      if (a2_spc_r) begin
        out_s_r <= a2_spcv_r;
      end else if (a2_zero_r) begin
        out_s_r <= 32'd0;
      end else begin
        out_s_r <= f_round_pack(a2_sign_r, a2_e_r, a2_sig_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;
  assign out_s     = out_s_r;

endmodule

@@ rtl/fsn_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsn_step : one Newton refinement, x <= 0.5 * (x + num / x)
// Divider, adder and a halving stage in series. 34 register stages.
// ----------------------------------------------------------------------------
module fsn_step import fsn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  fsn_tag_t in_tag,
  output logic     out_valid,
  output fsn_tag_t out_tag
);

  logic        dv_valid, ad_valid;
  fsn_tag_t    dv_tag, ad_tag;
  logic [31:0] dv_q, ad_s;

  fsn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_tag    (in_tag),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_q     (dv_q)
  );

  fsn_add u_add (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_tag    (dv_tag),
    .in_q      (dv_q),
    .out_valid (ad_valid),
    .out_tag   (ad_tag),
    .out_s     (ad_s)
  );

  // halve: exponent down by one, or a rounded shift in the subnormal range
  logic [31:0] half_nxt;
  logic [23:0] hs, hr;

  always_comb begin
    hs = {ad_s[23], ad_s[22:0]};
    hr = {1'b0, hs[23:1]} + {23'd0, hs[0] & hs[1]};
    if (f_is_nan(ad_s)) begin
      half_nxt = f_quiet(ad_s);
    end else if (ad_s[30:23] == 8'hFF) begin
      half_nxt = ad_s;
    end else if (ad_s[30:23] > 8'd1) begin
      half_nxt = {ad_s[31], ad_s[30:23] - 8'd1, ad_s[22:0]};
    end else begin
      half_nxt = {ad_s[31], 7'd0, hr};
    end
  end

  logic     out_valid_r;
  fsn_tag_t out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ad_valid;
    end
    if (en) begin
      out_tag_r.err <= ad_tag.err;
      out_tag_r.num <= ad_tag.num;
      out_tag_r.x   <= half_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;

endmodule

@@ rtl/float_sqrt_newton.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_sqrt_newton : single-precision square root by seed and Newton steps
// Takes one operand per cycle unless stalled. Each result passes through the
// seed register, which loads on the input transfer itself, then 34 stages for
// each of the two Newton steps (the 26-stage restoring divider dominates) and
// the output register. A stall on the output freezes the whole pipeline only
// when its last stage holds a result; otherwise inputs keep flowing. Negative
// operands other than -0 and NaN, -inf included, return zero with tuser set.
// ----------------------------------------------------------------------------
module float_sqrt_newton import fsn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] root_bits
  output logic [0:0]  out_tuser   // [0] negative_error
);

  logic     pipe_en;
  logic     sv [NEWTON_STEPS+1];
  fsn_tag_t st [NEWTON_STEPS+1];

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_err_r;

  assign pipe_en   = !sv[NEWTON_STEPS] || !out_valid_r || out_tready;
  assign in_tready = pipe_en;

  // seed
  logic [31:0] seed_nxt;
  logic        err_nxt;

  always_comb begin
    err_nxt  = in_tdata[31] && !f_is_zero(in_tdata) && !f_is_nan(in_tdata);
    seed_nxt = ((in_tdata - SEED_SUB) >> 1) + SEED_ADD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv[0] <= 1'b0;
    end else if (pipe_en) begin
      sv[0] <= in_tvalid;
    end
    if (pipe_en) begin
      st[0].err <= err_nxt;
      st[0].num <= in_tdata;
      st[0].x   <= seed_nxt;
    end
  end

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    fsn_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (sv[k]),
      .in_tag    (st[k]),
      .out_valid (sv[k+1]),
      .out_tag   (st[k+1])
    );
  end

  // hold the result until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      out_valid_r <= sv[NEWTON_STEPS];
    end
    if (out_tready || !out_valid_r) begin
      out_err_r  <= st[NEWTON_STEPS].err;
      out_data_r <= st[NEWTON_STEPS].err ? 32'd0 : st[NEWTON_STEPS].x;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("error result with nonzero root");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && sv[NEWTON_STEPS])
    else $error("input stalled without a blocked output");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> sv[NEWTON_STEPS] && $stable(st[NEWTON_STEPS]))
    else $error("last stage changed during stall");
`endif

endmodule

@@ verif/float_sqrt_newton_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_sqrt_newton_tb : self-checking bench for the Newton square root
// Streams IEEE single operands, directed corner patterns first and then
// random ones, with random gaps on both sides and one long output hold-off.
// A bit-exact soft-float model of the seed and Newton steps predicts every
// result. Results are checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module float_sqrt_newton_tb;
  import fsn_pkg::*;

  typedef struct packed {
    logic [31:0] root;
    logic        neg;
  } root_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] operand_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] root_bits
  logic [0:0]  out_tuser;  // [0] negative_error

  logic [31:0] operand_q[$];
  root_t       root_q[$];
  int          fails;
  int          cycle;
  int          hold_cnt;

  float_sqrt_newton i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_inf(input logic [31:0] v);
    return v[30:0] == 31'h7F80_0000;
  endfunction

  function automatic void unpack(input logic [31:0] v, output logic [63:0] m,
                                 output longint ex);
    if (v[30:23] == 8'd0) begin
      m  = {41'd0, v[22:0]};
      ex = -149;
    end else begin
      m  = {40'd0, 1'b1, v[22:0]};
      ex = longint'(v[30:23]) - 150;
    end
    for (int i = 0; i < 24; i++) begin
      if (m != 64'd0 && !m[23]) begin
        m  = m << 1;
        ex = ex - 1;
      end
    end
  endfunction

  // value = sig * 2^ex, plus a nonzero tail when stk is set
  function automatic logic [31:0] pack_single(input logic sgn, input longint ex,
                                              input logic [63:0] sig,
                                              input logic stk);
    int          p;
    longint      sh;
    longint      bexp;
    logic [63:0] mant;
    logic        rnd;
    logic        rest;
    p = 0;
    if (sig == 64'd0) return {sgn, 31'd0};
    for (int i = 0; i < 64; i++) if (sig[i]) p = i;
    sh = p - 23;
    if (sh < -149 - ex) sh = -149 - ex;
    if (sh <= 0) begin
      mant = sig << (-sh);
      rnd  = 1'b0;
      rest = stk;
    end else if (sh > 63) begin
      mant = 64'd0;
      rnd  = 1'b0;
      rest = 1'b1;
    end else begin
      mant = sig >> sh;
      rnd  = sig[sh-1];
      rest = stk | (|(sig & ((64'd1 << (sh - 1)) - 64'd1)));
    end
    if (rnd && (rest || mant[0])) mant = mant + 64'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      sh   = sh + 1;
    end
    if (mant[23]) begin
      bexp = sh + ex + 150;
      if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, bexp[7:0], mant[22:0]};
    end
    return {sgn, 8'd0, mant[22:0]};
  endfunction

  function automatic logic [31:0] fp_div(input logic [31:0] n, input logic [31:0] d);
    logic        sgn;
    logic [63:0] mn;
    logic [63:0] md;
    longint      en;
    longint      ed;
    sgn = n[31] ^ d[31];
    if (d[30:0] == 31'd0) begin
      if (n[30:0] == 31'd0 || is_nan(n)) return QNAN_POS;
      return {sgn, 8'hFF, 23'd0};
    end
    if (is_nan(n)) return n | QUIET_BIT;
    if (is_nan(d)) return d | QUIET_BIT;
    if (is_inf(n) && is_inf(d)) return QNAN_DEF;
    if (is_inf(n)) return {sgn, 8'hFF, 23'd0};
    if (is_inf(d) || n[30:0] == 31'd0) return {sgn, 31'd0};
    unpack(n, mn, en);
    unpack(d, md, ed);
    return pack_single(sgn, en - ed - 40, (mn << 40) / md, ((mn << 40) % md) != 64'd0);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] mh;
    logic [63:0] ml;
    longint      eh;
    longint      el;
    longint      dif;
    longint      sum;
    logic [63:0] mag;
    if (is_nan(a)) return a | QUIET_BIT;
    if (is_nan(b)) return b | QUIET_BIT;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN_DEF;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    unpack(a, mh, eh);
    unpack(b, ml, el);
    hi = a;
    lo = b;
    if (el > eh) begin
      hi = b;
      lo = a;
      unpack(b, mh, eh);
      unpack(a, ml, el);
    end
    dif = eh - el;
    if (dif > 32) begin
      // far operand only shifts the tail
      mag = mh << 2;
      if (hi[31] != lo[31]) mag = mag - 64'd1;
      return pack_single(hi[31], eh - 2, mag, 1'b1);
    end
    sum = (hi[31] ? -longint'(mh << dif) : longint'(mh << dif)) +
          (lo[31] ? -longint'(ml) : longint'(ml));
    if (sum == 0) return {hi[31] & lo[31], 31'd0};
    if (sum < 0) return pack_single(1'b1, el, 64'(-sum), 1'b0);
    return pack_single(1'b0, el, 64'(sum), 1'b0);
  endfunction

  function automatic logic [31:0] fp_half(input logic [31:0] s);
    logic [63:0] m;
    longint      ex;
    if (is_nan(s)) return s | QUIET_BIT;
    if (is_inf(s)) return s;
    unpack(s, m, ex);
    return pack_single(s[31], ex - 1, m, 1'b0);
  endfunction

  function automatic root_t predict_root(input logic [31:0] op);
    root_t       r;
    logic [31:0] x;
    if (op[31] && op[30:0] != 31'd0 && op[30:0] <= 31'h7F80_0000) begin
      r.root = 32'd0;
      r.neg  = 1'b1;
      return r;
    end
    x = ((op - SEED_SUB) >> 1) + SEED_ADD;
    for (int k = 0; k < NEWTON_STEPS; k++) x = fp_half(fp_add(x, fp_div(op, x)));
    r.root = x;
    r.neg  = 1'b0;
    return r;
  endfunction

  function automatic bit calm();
    return cycle > 3000 && cycle < 7000;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 32'd0;
    end else if (!in_tvalid || in_tready) begin
      if (operand_q.size() > 0 && (calm() || $urandom_range(99) >= 6)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= operand_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle    <= 0;
      hold_cnt <= 0;
    end else begin
      cycle <= cycle + 1;
      if (cycle == 600) hold_cnt <= 400;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cnt > 1 || cycle == 600) out_tready <= 1'b0;
    else out_tready <= calm() || $urandom_range(99) >= 6;
  end

  always @(posedge clk) begin
    root_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) root_q.push_back(predict_root(in_tdata));
      if (out_tvalid && out_tready) begin
        if (root_q.size() == 0) begin
          $error("unexpected transfer root_bits=%h", out_tdata);
          fails = fails + 1;
        end else begin
          want = root_q.pop_front();
          if (out_tdata !== want.root) begin
            $error("root_bits expected %h actual %h", want.root, out_tdata);
            fails = fails + 1;
          end
          if (out_tuser[0] !== want.neg) begin
            $error("negative_error expected %b actual %b", want.neg, out_tuser[0]);
            fails = fails + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 300000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] random_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return {1'b0, 8'($urandom_range(90, 170)), 23'($urandom)};
    if (pick < 70) return {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
    if (pick < 78) return {1'b0, 8'd0, 23'($urandom)};
    if (pick < 84) return {1'($urandom), 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
    return $urandom;
  endfunction

  initial begin
    logic [31:0] corners[$];
    fails     = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 32'd0;
    out_tready = 1'b0;
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'h7FC0_0000, 32'hFFC0_0000, 32'h7F80_0001, 32'hFF80_0001,
                32'h0000_0001, 32'h0000_0002, 32'h007F_FFFF, 32'h0080_0000,
                32'h7F7F_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
                32'h3E80_0000, 32'hBF80_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 32'hFF7F_FFFF, 32'h4B18_9680};
    foreach (corners[i]) operand_q.push_back(corners[i]);
    for (int i = 0; i < 650; i++) operand_q.push_back(random_operand());
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (operand_q.size() == 0 && !in_tvalid && root_q.size() == 0);
    repeat (150) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
